// File: hw/rtl/brb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the byte ring buffer
// Sizes, command and status codes, payload structs and the control and
// status bundles that pass between the controller, datapath and output queue.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int RING_BYTES = 1024;
    localparam int MAX_PEEK   = 64;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 11;
    localparam int OFF_W  = 10;
    localparam int STAT_W = 2;

    localparam int ADDR_W = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int CNT_W  = $clog2(RING_BYTES + 1);
    localparam int PK_W   = $clog2(MAX_PEEK + 1);
    // Width that holds any sum of two lengths, offsets or counts.
    localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data_byte;
        logic              first_of_chunk;
        logic [LEN_W-1:0]  length;
        logic [OFF_W-1:0]  peek_offset;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] out_byte;
        logic [LEN_W-1:0]  count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic accept;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic peek_go;
        logic peek_one_left;
        logic rd_pending;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } oq_status_t;

endpackage

// File: hw/rtl/brb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/brb_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_outq: two-entry result queue
// Holds finished results so that the next item can be taken while a
// result still waits for the downstream side.
// ----------------------------------------------------------------------------
module brb_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brb_pkg::result_t    push_item,
    output logic                result_valid,
    input  logic                result_stall,
    output brb_pkg::result_t    result,
    output brb_pkg::oq_status_t status
);

    brb_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;
    logic             pop;

    assign result_valid = (level_reg != 2'd0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    assign status.level = level_reg;
    assign status.pop   = pop;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The controller's credit check must never let a push land on a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != 2'd2 || pop))
        else $error("result pushed into a full queue");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg != 2'd3)
        else $error("result queue level out of range");

endmodule

// File: hw/rtl/brb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_datapath: ring storage, pointers and request checks
// Decodes the offered item against the fill level, updates the pointers on
// a transfer, and streams peek bytes out of the byte store.
// ----------------------------------------------------------------------------
module brb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  brb_pkg::item_t      item,
    input  brb_pkg::ctrl_cmd_t  cmd,
    output brb_pkg::dp_status_t status,
    output logic                push,
    output brb_pkg::result_t    push_item
);

    localparam int AW = brb_pkg::ADDR_W;
    localparam int CW = brb_pkg::CNT_W;
    localparam int PW = brb_pkg::PK_W;
    localparam int SW = brb_pkg::CMP_W;
    localparam int LW = brb_pkg::LEN_W;

    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] chunk_left_reg, chunk_left_next;
    logic [AW-1:0] peek_addr_reg, peek_addr_next;
    logic [PW-1:0] peek_left_reg, peek_left_next;
    logic [PW-1:0] peek_len_reg, peek_len_next;
    logic          rd_pending_reg, rd_pending_next;
    logic          last_pending_reg, last_pending_next;

    logic [SW-1:0]   len_ext;
    logic [SW-1:0]   off_ext;
    logic [SW-1:0]   avail_ext;
    logic [SW-1:0]   free_ext;
    logic            do_write;
    logic            do_skip;
    logic            peek_go;
    logic [CW-1:0]   left_after;
    brb_pkg::result_t item_res;
    logic [brb_pkg::DATA_W-1:0] ram_rd_data;

    // Brings a sum below twice the ring size back into the ring.
    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] fixed;
        fixed = (sum >= SW'(brb_pkg::RING_BYTES)) ? sum - SW'(brb_pkg::RING_BYTES) : sum;
        return fixed[AW-1:0];
    endfunction

    assign len_ext   = SW'(item.length);
    assign off_ext   = SW'(item.peek_offset);
    assign avail_ext = SW'(fill_reg);
    assign free_ext  = SW'(brb_pkg::RING_BYTES) - avail_ext;

    // Request checks, evaluated on the offered item every cycle.
    always_comb
    begin
        do_write        = 1'b0;
        do_skip         = 1'b0;
        peek_go         = 1'b0;
        left_after      = chunk_left_reg;
        item_res.status   = brb_pkg::ST_NO_ROOM;
        item_res.out_byte = '0;
        item_res.count    = '0;
        item_res.last     = 1'b1;
        unique case (item.command)
            brb_pkg::CMD_WRITE:
            begin
                if (item.first_of_chunk)
                begin
                    left_after = '0;
                    if (len_ext == '0)
                    begin
                        item_res.status = brb_pkg::ST_OK;
                    end
                    else if (len_ext <= free_ext)
                    begin
                        do_write        = 1'b1;
                        left_after      = CW'(len_ext - SW'(1));
                        item_res.status = brb_pkg::ST_OK;
                        item_res.count  = LW'(1);
                    end
                end
                else if (chunk_left_reg != '0)
                begin
                    do_write        = 1'b1;
                    left_after      = chunk_left_reg - CW'(1);
                    item_res.status = brb_pkg::ST_OK;
                    item_res.count  = LW'(1);
                end
            end
            brb_pkg::CMD_PEEK:
            begin
                if (len_ext > SW'(brb_pkg::MAX_PEEK))
                begin
                    item_res.status = brb_pkg::ST_TOO_LONG;
                end
                else if (off_ext + len_ext <= avail_ext)
                begin
                    item_res.status = brb_pkg::ST_OK;
                    peek_go         = (len_ext != '0);
                end
            end
            brb_pkg::CMD_SKIP:
            begin
                if (len_ext <= avail_ext)
                begin
                    do_skip         = 1'b1;
                    item_res.status = brb_pkg::ST_OK;
                    item_res.count  = item.length;
                end
            end
            default:
            begin
                item_res.status = brb_pkg::ST_NO_ROOM;
            end
        endcase
    end

    always_comb
    begin
        wr_addr_next      = wr_addr_reg;
        rd_addr_next      = rd_addr_reg;
        fill_next         = fill_reg;
        chunk_left_next   = chunk_left_reg;
        peek_addr_next    = peek_addr_reg;
        peek_left_next    = peek_left_reg;
        peek_len_next     = peek_len_reg;
        rd_pending_next   = cmd.issue;
        last_pending_next = last_pending_reg;

        if (cmd.accept)
        begin
            chunk_left_next = left_after;
            if (do_write)
            begin
                wr_addr_next = ring_wrap(SW'(wr_addr_reg) + SW'(1));
                fill_next    = fill_reg + CW'(1);
            end
            if (do_skip)
            begin
                rd_addr_next = ring_wrap(SW'(rd_addr_reg) + len_ext);
                fill_next    = CW'(avail_ext - len_ext);
            end
            if (peek_go)
            begin
                peek_addr_next = ring_wrap(SW'(rd_addr_reg) + off_ext);
                peek_left_next = PW'(item.length);
                peek_len_next  = PW'(item.length);
            end
        end

        if (cmd.issue)
        begin
            peek_addr_next    = ring_wrap(SW'(peek_addr_reg) + SW'(1));
            peek_left_next    = peek_left_reg - PW'(1);
            last_pending_next = (peek_left_reg == PW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg    <= '0;
            rd_addr_reg    <= '0;
            fill_reg       <= '0;
            chunk_left_reg <= '0;
            peek_left_reg  <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            wr_addr_reg    <= wr_addr_next;
            rd_addr_reg    <= rd_addr_next;
            fill_reg       <= fill_next;
            chunk_left_reg <= chunk_left_next;
            peek_left_reg  <= peek_left_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        peek_addr_reg    <= peek_addr_next;
        peek_len_reg     <= peek_len_next;
        last_pending_reg <= last_pending_next;
    end

    brb_ram #(
        .WIDTH (brb_pkg::DATA_W),
        .DEPTH (brb_pkg::RING_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.accept && do_write),
        .wr_addr (wr_addr_reg),
        .wr_data (item.data_byte),
        .rd_en   (cmd.issue),
        .rd_addr (peek_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign status.peek_go       = peek_go;
    assign status.peek_one_left = (peek_left_reg == PW'(1));
    assign status.rd_pending    = rd_pending_reg;

    // A peek byte lands in the cycle after its read; no item is taken meanwhile.
    always_comb
    begin
        push = rd_pending_reg || (cmd.accept && !peek_go);
        if (rd_pending_reg)
        begin
            push_item.status   = brb_pkg::ST_OK;
            push_item.out_byte = ram_rd_data;
            push_item.count    = LW'(peek_len_reg);
            push_item.last     = last_pending_reg;
        end
        else
        begin
            push_item = item_res;
        end
    end

endmodule

// File: hw/rtl/brb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl: sequencing controller
// Decides when an item transfer may happen and paces the byte reads of a
// peek against the space left in the result queue.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  brb_pkg::dp_status_t dp,
    input  brb_pkg::oq_status_t oq,
    output brb_pkg::ctrl_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PEEK = 1'b1;

    logic       state_reg;
    logic       state_next;
    logic [2:0] occupancy;

    // Queue entries plus the read still on its way from the store.
    assign occupancy = {1'b0, oq.level} + {2'b00, dp.rd_pending};

    assign item_stall = !((state_reg == S_IDLE) && !dp.rd_pending
                          && ((oq.level != 2'd2) || oq.pop));
    assign cmd.accept = item_valid && !item_stall;
    assign cmd.issue  = (state_reg == S_PEEK)
                        && ((occupancy < 3'd2) || ((occupancy == 3'd2) && oq.pop));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && dp.peek_go)
                begin
                    state_next = S_PEEK;
                end
            end
            S_PEEK:
            begin
                if (cmd.issue && dp.peek_one_left)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_issue_in_peek: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg == S_PEEK))
        else $error("store read issued outside a peek run");

    a_peek_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && dp.peek_go) |=> !cmd.accept)
        else $error("item taken while a peek run was starting");

    a_last_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && dp.peek_one_left) |=> (dp.rd_pending && item_stall))
        else $error("final peek byte not pending after its read");

endmodule

// File: hw/rtl/byte_ring_buffer_peek_skip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_skip: byte ring buffer with peek and skip
// Top level joining the controller, datapath and result queue.
// ----------------------------------------------------------------------------
// A write byte, a skip, a refused request or a zero-length peek gives one
// result; a peek of n bytes holds the input until its last byte has landed,
// since the byte store is read one byte per cycle while the result queue has
// room, through its single registered read port, and the last byte lands in
// the cycle after its read. Results pass through a two-entry queue, so the
// next item is taken while a result still waits, and a stalled output slows
// peeks to the drain rate. The byte store has no reset and needs no clearing
// pass; the block takes items from the first cycle after reset.
module byte_ring_buffer_peek_skip (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  brb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output brb_pkg::result_t result
);

    brb_pkg::ctrl_cmd_t  cmd;
    brb_pkg::dp_status_t dp_status;
    brb_pkg::oq_status_t oq_status;
    logic                push;
    brb_pkg::result_t    push_item;

    brb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp         (dp_status),
        .oq         (oq_status),
        .cmd        (cmd)
    );

    brb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (dp_status),
        .push      (push),
        .push_item (push_item)
    );

    brb_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .status       (oq_status)
    );

endmodule

// File: bench/tb_byte_ring_buffer_peek_skip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_peek_skip: self-checking bench for the byte ring buffer
// A short table of directed items covers the empty and refusal cases and
// short chunks with peeks and skips, then random chunks, peeks, skips and
// noise follow. Every result transfer is checked against the row's written-out
// result or a behavioral bench copy of the ring. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_peek_skip;

    localparam logic [brb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 70;
    localparam int REPORT_MAX    = 10;
    localparam int STALL_RUN_MAX = 4;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LEN_MAX       = (1 << brb_pkg::LEN_W) - 1;
    localparam int OFF_MAX       = (1 << brb_pkg::OFF_W) - 1;

    typedef struct {
        brb_pkg::item_t   it;
        bit               typed;
        brb_pkg::result_t want;
    } stim_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    brb_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    brb_pkg::result_t result;

    // Bench copy of the ring.
    logic [brb_pkg::DATA_W-1:0] ring_mem [brb_pkg::RING_BYTES];
    logic [brb_pkg::ADDR_W:0]   wr_ptr     = '0;
    logic [brb_pkg::ADDR_W:0]   rd_ptr     = '0;
    logic                       chunk_open = 1'b0;
    logic [brb_pkg::LEN_W-1:0]  chunk_due  = '0;

    brb_pkg::result_t due_results[$];
    stim_row_t        stim_table[$];

    int mismatch_count = 0;
    int sent_count     = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int stall_hold     = 0;
    int stall_run      = 0;
    int cycle_count    = 0;

    byte_ring_buffer_peek_skip uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic int ring_fill();
        logic [brb_pkg::ADDR_W:0] diff;
        diff = wr_ptr - rd_ptr;
        return int'(diff);
    endfunction

    function automatic brb_pkg::item_t make_item(input logic [brb_pkg::CMD_W-1:0] cmd,
                                                 input logic [brb_pkg::DATA_W-1:0] data,
                                                 input logic first, input int len,
                                                 input int off);
        brb_pkg::item_t it;
        it.command        = cmd;
        it.data_byte      = data;
        it.first_of_chunk = first;
        it.length         = brb_pkg::LEN_W'(len);
        it.peek_offset    = brb_pkg::OFF_W'(off);
        return it;
    endfunction

    // Applies one accepted item to the bench ring and queues the results it causes.
    // A typed row queues its written-out result instead, but still moves the state.
    task automatic ring_step(input brb_pkg::item_t it, input bit typed,
                             input brb_pkg::result_t want);
        brb_pkg::result_t           outs[$];
        brb_pkg::result_t           r;
        logic [brb_pkg::ADDR_W-1:0] idx;
        int                         avail;
        int                         len;
        int                         off;
        int                         i;
        avail    = ring_fill();
        len      = int'(it.length);
        off      = int'(it.peek_offset);
        r        = '0;
        r.status = brb_pkg::ST_NO_ROOM;
        r.last   = 1'b1;
        case (it.command)
            brb_pkg::CMD_WRITE:
            begin
                if (it.first_of_chunk)
                begin
                    chunk_open = 1'b0;
                    chunk_due  = '0;
                    if (len == 0)
                        r.status = brb_pkg::ST_OK;
                    else if (len <= brb_pkg::RING_BYTES - avail)
                    begin
                        chunk_open = 1'b1;
                        chunk_due  = it.length;
                    end
                end
                if (chunk_open && chunk_due != 0)
                begin
                    ring_mem[wr_ptr[brb_pkg::ADDR_W-1:0]] = it.data_byte;
                    wr_ptr    = wr_ptr + 1'b1;
                    chunk_due = chunk_due - 1'b1;
                    if (chunk_due == 0)
                        chunk_open = 1'b0;
                    r.status = brb_pkg::ST_OK;
                    r.count  = brb_pkg::LEN_W'(1);
                end
            end
            brb_pkg::CMD_PEEK:
            begin
                if (len > brb_pkg::MAX_PEEK)
                    r.status = brb_pkg::ST_TOO_LONG;
                else if (off + len <= avail)
                begin
                    r.status = brb_pkg::ST_OK;
                    for (i = 0; i < len; i++)
                    begin
                        idx        = rd_ptr[brb_pkg::ADDR_W-1:0]
                                     + brb_pkg::ADDR_W'(off + i);
                        r.out_byte = ring_mem[idx];
                        r.count    = it.length;
                        r.last     = (i == len - 1);
                        outs.push_back(r);
                    end
                end
            end
            brb_pkg::CMD_SKIP:
            begin
                if (len <= avail)
                begin
                    rd_ptr   = rd_ptr + it.length;
                    r.status = brb_pkg::ST_OK;
                    r.count  = it.length;
                end
            end
            default:
            begin
            end
        endcase
        if (outs.size() == 0)
            outs.push_back(r);
        if (typed)
            due_results.push_back(want);
        else
            foreach (outs[k])
                due_results.push_back(outs[k]);
    endtask

    // Holds the item until its transfer, then idles the input now and then.
    task automatic send_item(input brb_pkg::item_t it, input bit typed = 1'b0,
                             input brb_pkg::result_t want = '0);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        ring_step(it, typed, want);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic row_known(input logic [brb_pkg::CMD_W-1:0] cmd,
                             input logic [brb_pkg::DATA_W-1:0] data,
                             input logic first, input int len, input int off,
                             input logic [brb_pkg::STAT_W-1:0] st, input int cnt);
        stim_row_t row;
        row.it          = make_item(cmd, data, first, len, off);
        row.typed       = 1'b1;
        row.want        = '0;
        row.want.status = st;
        row.want.count  = brb_pkg::LEN_W'(cnt);
        row.want.last   = 1'b1;
        stim_table.push_back(row);
    endtask

    task automatic row_model(input logic [brb_pkg::CMD_W-1:0] cmd,
                             input logic [brb_pkg::DATA_W-1:0] data,
                             input logic first, input int len, input int off);
        stim_row_t row;
        row.it    = make_item(cmd, data, first, len, off);
        row.typed = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endtask

    task automatic random_peek();
        int avail;
        int cap;
        int len;
        int off;
        avail = ring_fill();
        if (avail > 0 && $urandom_range(0, 4) != 0)
        begin
            cap = (avail < brb_pkg::MAX_PEEK) ? avail : brb_pkg::MAX_PEEK;
            len = $urandom_range(0, 1) ? $urandom_range(1, (cap < 8) ? cap : 8)
                                       : $urandom_range(1, cap);
            off = $urandom_range(0, avail - len);
        end
        else
        begin
            len = $urandom_range(0, 1) ? $urandom_range(0, brb_pkg::MAX_PEEK + 1)
                                       : $urandom_range(0, LEN_MAX);
            off = $urandom_range(0, OFF_MAX);
        end
        send_item(make_item(brb_pkg::CMD_PEEK, brb_pkg::DATA_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), len, off));
    endtask

    task automatic random_skip();
        int avail;
        int len;
        avail = ring_fill();
        if ($urandom_range(0, 4) != 0)
            len = $urandom_range(0, (avail < 80) ? avail : 80);
        else
            len = $urandom_range(0, 1) ? avail + 1 : $urandom_range(0, LEN_MAX);
        send_item(make_item(brb_pkg::CMD_SKIP, brb_pkg::DATA_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), len, $urandom_range(0, OFF_MAX)));
    endtask

    task automatic random_noise();
        send_item(make_item(brb_pkg::CMD_W'($urandom_range(0, 3)),
                            brb_pkg::DATA_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)),
                            $urandom_range(0, LEN_MAX), $urandom_range(0, OFF_MAX)));
    endtask

    // A chunk with random data; sometimes cut short, interrupted by a peek or
    // skip, or followed by a stray byte.
    task automatic random_chunk();
        int free_bytes;
        int pick;
        int len;
        int nbytes;
        int split;
        int i;
        free_bytes = brb_pkg::RING_BYTES - ring_fill();
        pick       = $urandom_range(0, 9);
        if (pick < 6)
            len = $urandom_range(1, 8);
        else if (pick < 8)
            len = $urandom_range(9, 40);
        else
            len = (free_bytes <= brb_pkg::MAX_PEEK) ? free_bytes + $urandom_range(0, 1)
                                                    : $urandom_range(1, 8);
        if (len == 0)
            nbytes = 0;
        else if (len > free_bytes)
            nbytes = (len - 1 < 3) ? len - 1 : 3;
        else
            nbytes = len - 1;
        if (len > 1 && $urandom_range(0, 9) == 0)
            nbytes = $urandom_range(0, len - 2);
        split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nbytes) : -1;
        send_item(make_item(brb_pkg::CMD_WRITE, brb_pkg::DATA_W'($urandom_range(0, 255)),
                            1'b1, len, $urandom_range(0, OFF_MAX)));
        for (i = 0; i < nbytes; i++)
        begin
            if (i == split)
            begin
                if ($urandom_range(0, 1))
                    random_peek();
                else
                    random_skip();
            end
            send_item(make_item(brb_pkg::CMD_WRITE,
                                brb_pkg::DATA_W'($urandom_range(0, 255)), 1'b0,
                                $urandom_range(0, LEN_MAX), $urandom_range(0, OFF_MAX)));
        end
        if ($urandom_range(0, 9) == 0)
            send_item(make_item(brb_pkg::CMD_WRITE,
                                brb_pkg::DATA_W'($urandom_range(0, 255)), 1'b0, 0, 0));
    endtask

    task automatic report_mismatch(input string what, input brb_pkg::result_t want,
                                   input brb_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s: expected status %0d byte %02h count %0d last %0b, %s%0d %s%02h %s%0d %s%0b",
                     $time, what, want.status, want.out_byte, want.count, want.last,
                     "got status ", got.status, "byte ", got.out_byte,
                     "count ", got.count, "last ", got.last);
    endtask

    // Checks each result transfer and drives the output stall pattern.
    always @(posedge clk)
    begin : result_check
        brb_pkg::result_t want;
        logic             stall_next;
        cycle_count++;
        if (rst_n && result_valid && result_stall == 1'b0)
        begin
            if (due_results.size() == 0)
                report_mismatch("result with none expected", '0, result);
            else
            begin
                want = due_results.pop_front();
                if (result.status !== want.status || result.out_byte !== want.out_byte ||
                    result.count !== want.count || result.last !== want.last)
                    report_mismatch("result mismatch", want, result);
            end
        end
        stall_next = 1'b0;
        if (rst_n)
        begin
            if (stall_hold == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_hold = $urandom_range(16, 128);
            end
            else
                stall_hold--;
            case (stall_mode)
                0:       stall_next = 1'b0;
                1:       stall_next = 1'($urandom_range(0, 1));
                2:       stall_next = ($urandom_range(0, 3) != 0);
                default: stall_next = (cycle_count % 3 == 0);
            endcase
            if (stall_run >= STALL_RUN_MAX)
                stall_next = 1'b0;
            stall_run = stall_next ? stall_run + 1 : 0;
        end
        result_stall <= stall_next;
    end

    initial
    begin
        #5_000_000;
        $display("** byte_ring_buffer_peek_skip: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int start;
        int pick;

        // Empty ring: every refusal path and the zero-length cases.
        row_known(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 0, 0, brb_pkg::ST_OK, 0);
        row_known(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 0, OFF_MAX, brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_PEEK,  8'h00, 1'b0, brb_pkg::MAX_PEEK + 1, 0,
                  brb_pkg::ST_TOO_LONG, 0);
        row_known(brb_pkg::CMD_PEEK,  8'hFF, 1'b1, LEN_MAX, OFF_MAX, brb_pkg::ST_TOO_LONG, 0);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, 1, 0, brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, 0, 0, brb_pkg::ST_OK, 0);
        row_known(CMD_UNUSED,         8'hFF, 1'b1, LEN_MAX, OFF_MAX, brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_WRITE, 8'h5A, 1'b1, 0, 0, brb_pkg::ST_OK, 0);
        row_known(brb_pkg::CMD_WRITE, 8'h00, 1'b1, brb_pkg::RING_BYTES + 1, 0,
                  brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_WRITE, 8'h11, 1'b0, 0, 0, brb_pkg::ST_NO_ROOM, 0);
        // Three-byte chunk with a peek and a skip landing inside it.
        row_known(brb_pkg::CMD_WRITE, 8'hFF, 1'b1, 3, 0, brb_pkg::ST_OK, 1);
        row_model(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 1, 0);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, LEN_MAX, 0, brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_WRITE, 8'h00, 1'b0, 0, 0, brb_pkg::ST_OK, 1);
        row_known(brb_pkg::CMD_WRITE, 8'hA5, 1'b0, 0, 0, brb_pkg::ST_OK, 1);
        row_known(brb_pkg::CMD_WRITE, 8'h3C, 1'b0, 0, 0, brb_pkg::ST_NO_ROOM, 0);
        row_model(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 3, 0);
        row_known(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 3, 1, brb_pkg::ST_NO_ROOM, 0);
        row_model(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 1, 2);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, 4, 0, brb_pkg::ST_NO_ROOM, 0);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, 3, 0, brb_pkg::ST_OK, 3);
        // A new first byte abandons the open chunk.
        row_known(brb_pkg::CMD_WRITE, 8'h80, 1'b1, 2, 0, brb_pkg::ST_OK, 1);
        row_known(brb_pkg::CMD_WRITE, 8'h7F, 1'b1, 1, 0, brb_pkg::ST_OK, 1);
        row_known(brb_pkg::CMD_WRITE, 8'h01, 1'b0, 0, 0, brb_pkg::ST_NO_ROOM, 0);
        row_model(brb_pkg::CMD_PEEK,  8'h00, 1'b0, 2, 0);
        row_known(brb_pkg::CMD_SKIP,  8'h00, 1'b0, 2, 0, brb_pkg::ST_OK, 2);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[n])
            send_item(stim_table[n].it, stim_table[n].typed, stim_table[n].want);

        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                random_chunk();
            else if (pick < 70)
                random_peek();
            else if (pick < 90)
                random_skip();
            else
                random_noise();
        end
        item_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** byte_ring_buffer_peek_skip: PASSED **");
        else
            $display("** byte_ring_buffer_peek_skip: FAILED **");
        $finish;
    end

endmodule
